FILE: design/jos_pkg.sv
// ----------------------------------------------------------------------------
// jos_pkg
// Shared widths, constants and controller/datapath interface types for the
// josephus survivor core.
// ----------------------------------------------------------------------------
package jos_pkg;

    // circle size and survivor width
    localparam int C_NW = 11;
    // step count width
    localparam int C_MW = 10;
    // circle counter width, holds n + 1
    localparam int C_KW = 12;
    // width of r + m
    localparam int C_SW = 12;
    // number of restoring remainder steps, one per quotient bit
    localparam int C_DIV_STEPS = 11;
    // quotient bit index width
    localparam int C_JW = 4;
    // width of the shifted divisor
    localparam int C_DW = C_KW + C_DIV_STEPS - 1;

    localparam logic [C_MW-1:0] C_STEP_RESET = 10'd3;

    // commands from controller to datapath
    typedef struct packed {
        logic load;       // latch circle size and step, restart recurrence
        logic step;       // one recurrence step with a single subtract
        logic div_start;  // start remainder sweep for a large step
        logic div_step;   // one restoring remainder step
        logic out_set;    // capture the result
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic bad_size;   // empty or oversized circle
        logic done;       // recurrence has covered the whole circle
        logic need_div;   // r + m reaches twice the circle counter
        logic div_last;   // last remainder step
    } t_sts;

endpackage

FILE: design/jos_dpath.sv
// ----------------------------------------------------------------------------
// jos_dpath
// Datapath for the survivor recurrence r = (r + m) mod k, k = 2 .. n.
// Holds the step register, the recurrence state, a restoring remainder unit
// and the result registers.
// ----------------------------------------------------------------------------
module jos_dpath #(
    parameter int MAX_PEOPLE = 1024
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step_count_we,
    input  logic [jos_pkg::C_MW-1:0] i_step_count,
    input  logic [jos_pkg::C_NW-1:0] i_circle_size,
    input  jos_pkg::t_cmd          i_cmd,
    output jos_pkg::t_sts          o_sts,
    output logic [jos_pkg::C_NW-1:0] o_survivor,
    output logic                   o_survivor_valid
);
    import jos_pkg::*;

    localparam logic [31:0] C_MAX = 32'(MAX_PEOPLE);

    logic [C_MW-1:0] r_step;
    logic [C_NW-1:0] r_n;
    logic [C_MW-1:0] r_m;
    logic [C_KW-1:0] r_k;
    logic [C_NW-1:0] r_r;
    logic [C_SW-1:0] r_rem;
    logic [C_JW-1:0] r_j;
    logic [C_NW-1:0] r_survivor;
    logic            r_survivor_valid;

    logic [C_SW-1:0] sum;
    logic [C_KW:0]   two_k;
    logic [C_SW:0]   sum_minus_k;
    logic [C_DW-1:0] div_shift;
    logic [C_DW-1:0] rem_wide;
    logic [C_DW-1:0] rem_sub;
    logic [C_SW-1:0] n_rem;
    logic [C_NW-1:0] fast_r;

    // step register, zero behaves as one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= C_STEP_RESET;
        end else if (i_step_count_we) begin
            r_step <= i_step_count;
        end
    end

    // recurrence arithmetic
    assign sum         = C_SW'(r_r) + C_SW'(r_m);
    assign two_k       = {r_k, 1'b0};
    assign sum_minus_k = {1'b0, sum} - (C_SW+1)'(r_k);
    assign fast_r      = sum_minus_k[C_SW] ? C_NW'(sum) : C_NW'(sum_minus_k);

    // restoring remainder step against k shifted by the current bit index
    assign div_shift = C_DW'(r_k) << r_j;
    assign rem_wide  = C_DW'(r_rem);
    assign rem_sub   = rem_wide - div_shift;
    assign n_rem     = (rem_wide >= div_shift) ? C_SW'(rem_sub) : r_rem;

    // status
    assign o_sts.bad_size = (r_n == '0) || (32'(r_n) > C_MAX);
    assign o_sts.done     = (r_k > C_KW'(r_n));
    assign o_sts.need_div = ((C_KW+1)'(sum) >= two_k);
    assign o_sts.div_last = (r_j == '0);

    // recurrence state
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n <= i_circle_size;
            r_m <= (r_step == '0) ? C_MW'(1) : r_step;
            r_k <= C_KW'(2);
            r_r <= '0;
        end else if (i_cmd.step) begin
            r_r <= fast_r;
            r_k <= r_k + C_KW'(1);
        end else if (i_cmd.div_start) begin
            r_rem <= sum;
            r_j   <= C_JW'(C_DIV_STEPS - 1);
        end else if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_j   <= r_j - C_JW'(1);
            if (r_j == '0) begin
                r_r <= C_NW'(n_rem);
                r_k <= r_k + C_KW'(1);
            end
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_set) begin
            r_survivor       <= o_sts.bad_size ? '0 : r_r + C_NW'(1);
            r_survivor_valid <= !o_sts.bad_size;
        end
    end

    assign o_survivor       = r_survivor;
    assign o_survivor_valid = r_survivor_valid;

endmodule

FILE: design/jos_ctrl.sv
// ----------------------------------------------------------------------------
// jos_ctrl
// Controller for the survivor core: takes a request, sequences the
// recurrence steps and remainder sweeps, and holds the result until taken.
// ----------------------------------------------------------------------------
module jos_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_stall,
    input  jos_pkg::t_sts i_sts,
    output jos_pkg::t_cmd o_cmd
);
    import jos_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RUN,
        ST_DIV,
        ST_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_valid;
    logic   n_valid;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_valid = r_valid;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_sts.bad_size) begin
                    o_cmd.out_set = 1'b1;
                    n_valid       = 1'b1;
                    n_state       = ST_OUT;
                end else begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (i_sts.done) begin
                    o_cmd.out_set = 1'b1;
                    n_valid       = 1'b1;
                    n_state       = ST_OUT;
                end else if (i_sts.need_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_DIV;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_RUN;
                end
            end
            ST_OUT: begin
                if (!i_stall) begin
                    n_valid = 1'b0;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_valid = 1'b0;
                n_state = ST_IDLE;
            end
        endcase
    end

    // state and registered output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_valid;

endmodule

FILE: design/josephus_survivor_core.sv
// ----------------------------------------------------------------------------
// josephus_survivor_core
// Returns the last survivor of a Josephus circle for each requested size.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid / o_stall with i_circle_size. A request is taken
//   when i_valid is high and o_stall is low; o_stall is high from the taken
//   request until its result has been delivered.
//   Output channel: o_valid / i_stall with o_survivor and o_survivor_valid,
//   held stable while i_stall is high.
//   i_step_count_we writes i_step_count (0 acts as 1); write only when idle.
// Sequencing: an empty or oversized circle goes from the check state straight
//   to its result. Otherwise the survivor recurrence runs k = 2 .. n, with a
//   single subtract step per k while r + m stays below 2k, and otherwise an
//   11-step restoring remainder sweep for that k. Requests are handled one at
//   a time.
// Reset: synchronous, active low; clears the controller and sets the step
//   to 3. A stalled result simply waits; no new request is taken meanwhile.
// ----------------------------------------------------------------------------
module josephus_survivor_core #(
    parameter int MAX_PEOPLE = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_step_count_we,
    input  logic [jos_pkg::C_MW-1:0] i_step_count,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [jos_pkg::C_NW-1:0] i_circle_size,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [jos_pkg::C_NW-1:0] o_survivor,
    output logic                     o_survivor_valid
);
    import jos_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencing
    jos_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // recurrence and result
    jos_dpath #(
        .MAX_PEOPLE (MAX_PEOPLE)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step_count_we  (i_step_count_we),
        .i_step_count     (i_step_count),
        .i_circle_size    (i_circle_size),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_survivor       (o_survivor),
        .o_survivor_valid (o_survivor_valid)
    );

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for josephus_survivor_core. A queue of circle sizes
// feeds a clocked driver, a clocked monitor compares each survivor with a
// recurrence-based prediction made when the request is taken, and the step
// register is rewritten between drained phases, extremes included.
// ----------------------------------------------------------------------------
module tb_top;
    import jos_pkg::*;

    localparam int MAX_PEOPLE = 1024;

    // one predicted result, with the size that caused it for reporting
    typedef struct {
        logic [C_NW-1:0] circle_size;
        logic [C_NW-1:0] survivor;
        logic            survivor_valid;
    } t_survivor;

    logic            i_clk;
    logic            i_rst_n = 1'b0;
    logic            i_step_count_we = 1'b0;
    logic [C_MW-1:0] i_step_count = '0;
    logic            i_valid = 1'b0;
    logic            o_stall;
    logic [C_NW-1:0] i_circle_size = '0;
    logic            o_valid;
    logic            i_stall = 1'b0;
    logic [C_NW-1:0] o_survivor;
    logic            o_survivor_valid;

    logic [C_NW-1:0] circle_q[$];
    t_survivor       survivor_q[$];
    logic [C_MW-1:0] step_now = C_STEP_RESET;
    bit              calm = 1'b0;
    bit              req_done = 1'b0;
    int              fault_count = 0;

    josephus_survivor_core #(
        .MAX_PEOPLE(MAX_PEOPLE)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step_count_we (i_step_count_we),
        .i_step_count    (i_step_count),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_circle_size   (i_circle_size),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_survivor      (o_survivor),
        .o_survivor_valid(o_survivor_valid)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // survivor by the recurrence r(k) = (r(k-1) + m) mod k
    function automatic t_survivor predict_survivor(logic [C_NW-1:0] n, logic [C_MW-1:0] m);
        t_survivor   res;
        int unsigned r;
        int unsigned k;
        int unsigned stride;
        res.circle_size    = n;
        res.survivor       = '0;
        res.survivor_valid = 1'b0;
        if (n == 0 || n > MAX_PEOPLE) begin
            return res;
        end
        stride = (m == 0) ? 1 : m;
        r = 0;
        for (k = 2; k <= n; k++) begin
            r = (r + stride) % k;
        end
        res.survivor       = C_NW'(r + 1);
        res.survivor_valid = 1'b1;
        return res;
    endfunction

    function automatic bit take_break();
        return !calm && ($urandom_range(99) < 7);
    endfunction

    task automatic note_fault(string text);
        fault_count++;
        if (fault_count <= 10) begin
            $display("%s", text);
        end
    endtask

    // request driver, holds a request until it is taken
    always @(negedge i_clk) begin
        if (!i_valid || req_done) begin
            req_done = 1'b0;
            if (i_rst_n && circle_q.size() != 0 && !take_break()) begin
                i_valid       <= 1'b1;
                i_circle_size <= circle_q[0];
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result side back-pressure
    always @(negedge i_clk) begin
        i_stall <= take_break();
    end

    // request acceptance and result checking
    always @(posedge i_clk) begin
        t_survivor want;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                survivor_q.push_back(predict_survivor(i_circle_size, step_now));
                void'(circle_q.pop_front());
                req_done = 1'b1;
            end
            if (o_valid && !i_stall) begin
                if (survivor_q.size() == 0) begin
                    note_fault($sformatf("unexpected result: survivor %0d valid %0b",
                                         o_survivor, o_survivor_valid));
                end else begin
                    want = survivor_q.pop_front();
                    if (o_survivor !== want.survivor ||
                        o_survivor_valid !== want.survivor_valid) begin
                        note_fault($sformatf(
                            "size %0d step %0d: survivor exp %0d got %0d, valid exp %0b got %0b",
                            want.circle_size, step_now, want.survivor, o_survivor,
                            want.survivor_valid, o_survivor_valid));
                    end
                end
            end
        end
    end

    // wait until every queued request has been answered
    task automatic drain();
        while (circle_q.size() != 0 || survivor_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_step(logic [C_MW-1:0] value);
        @(negedge i_clk);
        i_step_count_we <= 1'b1;
        i_step_count    <= value;
        @(negedge i_clk);
        i_step_count_we <= 1'b0;
        step_now = value;
    endtask

    // mostly small circles, some empty, single, oversized and large ones
    function automatic logic [C_NW-1:0] pick_size();
        int roll;
        roll = $urandom_range(99);
        if (roll < 4) begin
            return '0;
        end else if (roll < 9) begin
            return C_NW'($urandom_range(2047, MAX_PEOPLE + 1));
        end else if (roll < 15) begin
            return C_NW'(1);
        end else if (roll < 24) begin
            return C_NW'($urandom_range(MAX_PEOPLE, 512));
        end
        return C_NW'($urandom_range(64, 2));
    endfunction

    // stimulus sequence
    initial begin
        logic [C_MW-1:0] steps[6];
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset step, size extremes and the classic 41-person circle
        circle_q = '{0, 1, 2, 3, 41, 1023, 1024, 1025, 2047, 7};
        drain();
        // zero step acts as one
        write_step(10'd0);
        circle_q = '{1, 2, 1024, 5};
        drain();
        write_step(10'd1023);
        circle_q = '{1024, 2, 1023, 100};
        drain();
        write_step(10'd1);
        circle_q = '{1024, 3};
        drain();

        // random phases, each with its own step
        steps[0] = 10'd2;
        steps[1] = C_MW'($urandom_range(1023, 1));
        steps[2] = 10'd1023;
        steps[3] = C_MW'($urandom_range(1023, 1));
        steps[4] = 10'd0;
        steps[5] = C_MW'($urandom_range(1023, 1));
        for (int p = 0; p < 6; p++) begin
            write_step(steps[p]);
            calm = (p == 1);
            for (int i = 0; i < 20; i++) begin
                circle_q.push_back(pick_size());
                // sender holds off mid phase until all results are back
                if (i == 9) begin
                    drain();
                end
            end
            drain();
        end
        calm = 1'b0;

        repeat (60) @(posedge i_clk);
        if (survivor_q.size() != 0) begin
            note_fault($sformatf("%0d results never arrived", survivor_q.size()));
        end
        if (fault_count == 0) begin
            $display("josephus_survivor_core: match");
        end else begin
            $display("josephus_survivor_core: mismatch");
        end
        $finish;
    end

    // run limit
    initial begin
        #100000000;
        $display("josephus_survivor_core: mismatch");
        $finish;
    end

endmodule
